FILE: src/gedge_pkg.sv
// Package: field widths, register indexes, reset values and output codes.
`timescale 1ns / 1ps
`default_nettype none

package gedge_pkg;

    // Payload field widths
    localparam int PIX_W    = 8;
    localparam int OUTX_W   = 11;
    localparam int OUTY_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Configuration register widths
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_THR_W    = 9;
    localparam int CFG_BORDER_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_VALUE   = 2'd3;

    // Reset values of the configuration registers
    localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH    = 12'd2048;
    localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT   = 16'd2048;
    localparam logic [CFG_THR_W-1:0]    RST_EDGE_THRESHOLD = 9'd60;
    localparam logic [CFG_BORDER_W-1:0] RST_BORDER_VALUE   = 8'd0;

    // Smallest frame dimension used
    localparam logic [CFG_HEIGHT_W-1:0] MIN_DIM = 16'd3;

    // Verdict codes
    localparam logic [PIX_W-1:0] EDGE_CODE    = 8'd0;
    localparam logic [PIX_W-1:0] NO_EDGE_CODE = 8'd255;

endpackage

`default_nettype wire

FILE: src/gedge_pix_if.sv
// Interface: pixel sample channel.
`timescale 1ns / 1ps
`default_nettype none

interface gedge_pix_if;
    logic                        valid;
    logic                        ready;
    logic [gedge_pkg::PIX_W-1:0] pixel_sample;

    modport source (output valid, output pixel_sample, input ready);
    modport sink   (input valid, input pixel_sample, output ready);
endinterface

`default_nettype wire

FILE: src/gedge_res_if.sv
// Interface: classified pixel result channel.
`timescale 1ns / 1ps
`default_nettype none

interface gedge_res_if;
    logic                         valid;
    logic                         ready;
    logic [gedge_pkg::PIX_W-1:0]  edge_value;
    logic [gedge_pkg::OUTX_W-1:0] out_x;
    logic [gedge_pkg::OUTY_W-1:0] out_y;
    logic                         last_of_run;

    modport source (output valid, output edge_value, output out_x, output out_y,
                    output last_of_run, input ready);
    modport sink   (input valid, input edge_value, input out_x, input out_y,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: src/gedge_cfg_if.sv
// Interface: configuration register write channel.
`timescale 1ns / 1ps
`default_nettype none

interface gedge_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gedge_pkg::CFG_IDX_W-1:0] index;
    logic [gedge_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/gradient_edge_threshold.sv
// Top level: streaming central-difference gradient edge detector with line buffers.
`timescale 1ns / 1ps
`default_nettype none

// Takes one 8-bit sample per cycle in raster order and, from row 1 on, emits the
// verdict for the pixel directly above each sample: 0 (edge) when
// dx*dx + dy*dy >= (edge_threshold+1)^2, else 255, and border_value for frame border
// pixels. Samples of the last row emit two results: the pixel above, then the
// sample itself as a border pixel. The datapath is three register stages (line
// buffer read, squaring, sum and compare into the output register). A sample
// passes the stage 1 and stage 2 registers before it loads the output register,
// and back-pressure can hold it in either. One sample is taken every cycle
// while the result port drains; on the last row each sample gives two results
// and the result port sets the pace. Two line buffers of MAX_WIDTH bytes each
// hold the previous rows; they start undefined and need no clearing pass.
// Configuration is written through its own channel, which is always ready. The user
// must write it only while no frame data is in flight; the block does not enforce it.
module gradient_edge_threshold #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    gedge_pix_if.sink       i_pix,
    gedge_cfg_if.sink       i_cfg,
    gedge_res_if.source     o_res
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WB = XW + 1;

    // Configuration registers
    logic [gedge_pkg::CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [gedge_pkg::CFG_HEIGHT_W-1:0] r_cfg_height;
    logic [gedge_pkg::CFG_THR_W-1:0]    r_cfg_thr;
    logic [gedge_pkg::CFG_BORDER_W-1:0] r_cfg_border;
    logic [19:0]                        r_thr_sq;

    // Line buffers
    logic [gedge_pkg::PIX_W-1:0] r_above_mem [MAX_WIDTH];
    logic [gedge_pkg::PIX_W-1:0] r_two_mem   [MAX_WIDTH];

    // Position counters
    logic [XW-1:0]                    r_col, n_col;
    logic [gedge_pkg::OUTY_W-1:0]     r_row, n_row;

    // Stage 1: sample, position and line buffer reads
    typedef struct packed {
        logic [XW-1:0]                x;
        logic [gedge_pkg::OUTY_W-1:0] py;
        logic [gedge_pkg::OUTY_W-1:0] y;
        logic                         emit;
        logic                         border;
        logic                         last_row;
    } t_meta;

    logic                        r1_valid;
    t_meta                       r1_meta;
    logic [gedge_pkg::PIX_W-1:0] r1_s;
    logic [gedge_pkg::PIX_W-1:0] r1_above;
    logic [gedge_pkg::PIX_W-1:0] r1_two;
    logic [gedge_pkg::PIX_W-1:0] r1_right;
    logic [gedge_pkg::PIX_W-1:0] r_left;

    // Stage 2: squared differences
    logic        r2_valid;
    t_meta       r2_meta;
    logic [15:0] r2_sq_x;
    logic [15:0] r2_sq_y;

    // Stage 3: output register
    logic                         r3_valid;
    logic                         r3_phase;
    logic                         r3_two;
    logic [gedge_pkg::PIX_W-1:0]  r3_value;
    logic [XW-1:0]                r3_x;
    logic [gedge_pkg::OUTY_W-1:0] r3_py;
    logic [gedge_pkg::OUTY_W-1:0] r3_y;

    // Handshake and stage movement
    logic out_fin, take3, load3, take2, load2, take1, accept, cfg_wr;

    assign out_fin = r3_valid && o_res.ready && (r3_phase || !r3_two);
    assign take3   = !r3_valid || out_fin;
    assign load3   = r2_valid && take3;
    assign take2   = !r2_valid || take3;
    assign load2   = r1_valid && take2;
    assign take1   = !r1_valid || take2;
    assign accept  = i_pix.valid && take1;

    assign i_pix.ready = take1;
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= gedge_pkg::RST_IMAGE_WIDTH;
            r_cfg_height <= gedge_pkg::RST_IMAGE_HEIGHT;
            r_cfg_thr    <= gedge_pkg::RST_EDGE_THRESHOLD;
            r_cfg_border <= gedge_pkg::RST_BORDER_VALUE;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                gedge_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg_width <= i_cfg.data[gedge_pkg::CFG_WIDTH_W-1:0];
                end
                gedge_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg_height <= i_cfg.data[gedge_pkg::CFG_HEIGHT_W-1:0];
                end
                gedge_pkg::REG_EDGE_THRESHOLD: begin
                    r_cfg_thr <= i_cfg.data[gedge_pkg::CFG_THR_W-1:0];
                end
                gedge_pkg::REG_BORDER_VALUE: begin
                    r_cfg_border <= i_cfg.data[gedge_pkg::CFG_BORDER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Squared threshold, (threshold + 1)^2
    logic [9:0]  thr_p1;
    logic [19:0] thr_sq;
    assign thr_p1 = {1'b0, r_cfg_thr} + 10'd1;
    assign thr_sq = thr_p1 * thr_p1;

    always_ff @(posedge i_clk) begin
        r_thr_sq <= thr_sq;
    end

    // Effective frame size
    logic [31:0]                  cfg_w_ext;
    logic [WB-1:0]                w_eff, wm1, x_ext, x_cur_ext;
    logic [gedge_pkg::OUTY_W-1:0] h_eff, hm1, y_cur;
    logic [XW-1:0]                x_cur, x_right;
    logic                         last_col, last_row;

    assign cfg_w_ext = 32'(r_cfg_width);

    always_comb begin
        if (cfg_w_ext < 32'(gedge_pkg::MIN_DIM)) begin
            w_eff = WB'(gedge_pkg::MIN_DIM);
        end else if (cfg_w_ext > 32'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(cfg_w_ext);
        end
    end

    assign wm1       = w_eff - WB'(1);
    assign x_ext     = {1'b0, r_col};
    assign x_cur_ext = (x_ext >= w_eff) ? wm1 : x_ext;
    assign x_cur     = x_cur_ext[XW-1:0];
    assign last_col  = (x_cur_ext == wm1);
    assign x_right   = last_col ? x_cur : XW'(x_cur_ext + WB'(1));

    assign h_eff    = (r_cfg_height < gedge_pkg::MIN_DIM) ? gedge_pkg::MIN_DIM : r_cfg_height;
    assign hm1      = h_eff - 16'd1;
    assign y_cur    = (r_row >= h_eff) ? hm1 : r_row;
    assign last_row = (y_cur == hm1);

    // Raster position counters
    always_comb begin
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : y_cur + 16'd1;
        end else begin
            n_col = XW'(x_cur_ext + WB'(1));
            n_row = y_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Row-above buffer: read here and to the right, write the new sample
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_above           <= r_above_mem[x_cur];
            r1_right           <= r_above_mem[x_right];
            r_above_mem[x_cur] <= i_pix.pixel_sample;
        end
    end

    // Row-two-above buffer: read on transfer, write back the row above as stage 1 loads stage 2
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_two <= r_two_mem[x_cur];
        end
        if (load2) begin
            r_two_mem[r1_meta.x] <= r1_above;
        end
    end

    // Stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (accept) begin
            r1_valid <= 1'b1;
        end else if (load2) begin
            r1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_s              <= i_pix.pixel_sample;
            r1_meta.x         <= x_cur;
            r1_meta.y         <= y_cur;
            r1_meta.py        <= y_cur - 16'd1;
            r1_meta.emit      <= (y_cur != '0);
            r1_meta.border    <= (x_cur == '0) || last_col || (y_cur == 16'd1);
            r1_meta.last_row  <= last_row;
        end
    end

    // Stage 2: differences and squares; left neighbor is the previous row-above read
    logic signed [8:0]  dx, dy;
    logic signed [17:0] dx_sq, dy_sq;

    assign dx    = $signed({1'b0, r1_right}) - $signed({1'b0, r_left});
    assign dy    = $signed({1'b0, r1_s}) - $signed({1'b0, r1_two});
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (load2) begin
            r2_valid <= 1'b1;
        end else if (load3) begin
            r2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load2) begin
            r_left  <= r1_above;
            r2_meta <= r1_meta;
            r2_sq_x <= dx_sq[15:0];
            r2_sq_y <= dy_sq[15:0];
        end
    end

    // Stage 3: magnitude compare into the output register
    logic [16:0]                 mag_sq;
    logic [gedge_pkg::PIX_W-1:0] verdict;

    assign mag_sq  = {1'b0, r2_sq_x} + {1'b0, r2_sq_y};
    assign verdict = r2_meta.border ? r_cfg_border :
                     (({3'b000, mag_sq} >= r_thr_sq) ? gedge_pkg::EDGE_CODE
                                                      : gedge_pkg::NO_EDGE_CODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r3_phase <= 1'b0;
        end else if (load3) begin
            r3_valid <= r2_meta.emit;
            r3_phase <= 1'b0;
        end else if (out_fin) begin
            r3_valid <= 1'b0;
            r3_phase <= 1'b0;
        end else if (r3_valid && o_res.ready) begin
            // first of two results taken, border result of the sample follows
            r3_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load3) begin
            r3_two   <= r2_meta.last_row;
            r3_value <= verdict;
            r3_x     <= r2_meta.x;
            r3_py    <= r2_meta.py;
            r3_y     <= r2_meta.y;
        end
    end

    // Result port
    assign o_res.valid       = r3_valid;
    assign o_res.edge_value  = r3_phase ? r_cfg_border : r3_value;
    assign o_res.out_x       = gedge_pkg::OUTX_W'(r3_x);
    assign o_res.out_y       = r3_phase ? r3_y : r3_py;
    assign o_res.last_of_run = r3_phase || !r3_two;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for gradient_edge_threshold: self-checking random and directed frame regression.
`timescale 1ns / 1ps

import gedge_pkg::*;

// One classified pixel as it leaves the block
typedef struct packed {
    logic [PIX_W-1:0]  edge_value;
    logic [OUTX_W-1:0] out_x;
    logic [OUTY_W-1:0] out_y;
    logic              last_of_run;
} edge_verdict_t;

// Line-buffer edge predictor plus the queue of verdicts still owed by the block
class edge_verdict_scoreboard #(int LINE_DEPTH = 2048);
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [CFG_THR_W-1:0]    thr_reg;
    logic [CFG_BORDER_W-1:0] border_reg;
    logic [PIX_W-1:0]        line_above[LINE_DEPTH];
    logic [PIX_W-1:0]        line_two_above[LINE_DEPTH];
    int unsigned             col_count;
    int unsigned             row_count;
    edge_verdict_t           verdicts_due[$];
    int unsigned             mismatches;

    function new();
        width_reg  = RST_IMAGE_WIDTH;
        height_reg = RST_IMAGE_HEIGHT;
        thr_reg    = RST_EDGE_THRESHOLD;
        border_reg = RST_BORDER_VALUE;
        foreach (line_above[i]) begin
            line_above[i]     = '0;
            line_two_above[i] = '0;
        end
        col_count  = 0;
        row_count  = 0;
        mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        case (idx)
            REG_IMAGE_WIDTH:    width_reg  = value[CFG_WIDTH_W-1:0];
            REG_IMAGE_HEIGHT:   height_reg = value[CFG_HEIGHT_W-1:0];
            REG_EDGE_THRESHOLD: thr_reg    = value[CFG_THR_W-1:0];
            REG_BORDER_VALUE:   border_reg = value[CFG_BORDER_W-1:0];
            default: ;
        endcase
    endfunction

    // Width saturates to the line buffer depth and to the minimum size
    function int unsigned used_width();
        int unsigned w;
        w = int'(width_reg);
        if (w < int'(MIN_DIM)) w = int'(MIN_DIM);
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        return w;
    endfunction

    function int unsigned used_height();
        int unsigned h;
        h = int'(height_reg);
        if (h < int'(MIN_DIM)) h = int'(MIN_DIM);
        return h;
    endfunction

    function int unsigned pending();
        return verdicts_due.size();
    endfunction

    // Accepted sample: advance the line buffers and queue the verdicts it causes
    function void take_sample(logic [PIX_W-1:0] s);
        int unsigned   w, h, x, y, mag2, t1;
        int            left, right, dx, dy;
        logic [PIX_W-1:0] above, two_above, v;
        bit            last_col, last_row;
        edge_verdict_t r;
        w = used_width();
        h = used_height();
        // counters left beyond a shrunken frame clamp to the last column / row
        x = (col_count >= w) ? w - 1 : col_count;
        y = (row_count >= h) ? h - 1 : row_count;
        last_col = (x == w - 1);
        last_row = (y == h - 1);
        above     = line_above[x];
        two_above = line_two_above[x];
        line_two_above[x] = above;
        line_above[x]     = s;
        if (y >= 1) begin
            if (x == 0 || last_col || y == 1) begin
                v = border_reg;
            end else begin
                left  = int'(line_two_above[x-1]);
                right = int'(line_above[x+1]);
                dx    = right - left;
                dy    = int'(s) - int'(two_above);
                mag2  = dx * dx + dy * dy;
                t1    = int'(thr_reg) + 1;
                v     = (mag2 >= t1 * t1) ? EDGE_CODE : NO_EDGE_CODE;
            end
            r.edge_value  = v;
            r.out_x       = x[OUTX_W-1:0];
            r.out_y       = OUTY_W'(y - 1);
            r.last_of_run = !last_row;
            verdicts_due.push_back(r);
            // last row also reports the sample itself as a border pixel
            if (last_row) begin
                r.edge_value  = border_reg;
                r.out_x       = x[OUTX_W-1:0];
                r.out_y       = y[OUTY_W-1:0];
                r.last_of_run = 1'b1;
                verdicts_due.push_back(r);
            end
        end
        if (last_col) begin
            col_count = 0;
            row_count = last_row ? 0 : y + 1;
        end else begin
            col_count = x + 1;
            row_count = y;
        end
    endfunction

    task flag_mismatch(string msg);
        mismatches++;
        $display("MISMATCH: %s", msg);
    endtask

    // Compare one delivered verdict with the oldest one owed
    task compare_verdict(edge_verdict_t got);
        edge_verdict_t want;
        if (verdicts_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected verdict value=%0d x=%0d y=%0d last=%0d",
                          got.edge_value, got.out_x, got.out_y, got.last_of_run));
            return;
        end
        want = verdicts_due.pop_front();
        if (got.edge_value !== want.edge_value)
            flag_mismatch($sformatf("edge_value at (%0d,%0d): got %0d want %0d",
                          want.out_x, want.out_y, got.edge_value, want.edge_value));
        if (got.out_x !== want.out_x)
            flag_mismatch($sformatf("out_x: got %0d want %0d (y=%0d)",
                          got.out_x, want.out_x, want.out_y));
        if (got.out_y !== want.out_y)
            flag_mismatch($sformatf("out_y: got %0d want %0d (x=%0d)",
                          got.out_y, want.out_y, want.out_x));
        if (got.last_of_run !== want.last_of_run)
            flag_mismatch($sformatf("last_of_run at (%0d,%0d): got %0b want %0b",
                          want.out_x, want.out_y, got.last_of_run, want.last_of_run));
    endtask

    task flag_leftovers();
        if (verdicts_due.size() != 0)
            flag_mismatch($sformatf("%0d verdicts never delivered", verdicts_due.size()));
    endtask
endclass

module tb;

    localparam int MAX_W          = 2048;
    localparam int SETTLE_CYCLES  = 8;
    localparam int FINAL_WAIT     = 20000;
    localparam int FINAL_SETTLE   = 16;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int HOLD_STRETCH   = 300;
    localparam int RANDOM_ITEMS   = 1600;

    // 3x3 frames for the directed part
    localparam logic [PIX_W-1:0] CHECKER_FRAME[9] = '{
        8'd0,   8'd255, 8'd0,
        8'd255, 8'd0,   8'd255,
        8'd0,   8'd255, 8'd0
    };
    localparam logic [PIX_W-1:0] STEEP_FRAME[9] = '{
        8'd0,   8'd0,   8'd0,
        8'd0,   8'd128, 8'd255,
        8'd255, 8'd255, 8'd0
    };

    logic i_clk;
    logic i_rst_n;

    gedge_pix_if pix ();
    gedge_cfg_if cfg ();
    gedge_res_if res ();

    gradient_edge_threshold #(.MAX_WIDTH(MAX_W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    edge_verdict_scoreboard #(MAX_W) sb;

    int unsigned      send_idle_pct;
    int unsigned      recv_idle_pct;
    int unsigned      hold_request;
    int unsigned      cycle_count;
    int unsigned      random_count;
    logic [PIX_W-1:0] last_pixel;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result sink: random back-pressure, or a long hold-off on request
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        res.ready  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                res.ready <= 1'b0;
                stall_left--;
            end else begin
                res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Monitors sample mid-cycle; a transfer seen here completes at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && pix.valid && pix.ready) sb.take_sample(pix.pixel_sample);
        if (i_rst_n && cfg.valid && cfg.ready) sb.write_reg(cfg.index, cfg.data);
    end

    always @(negedge i_clk) begin
        edge_verdict_t got;
        if (i_rst_n && res.valid && res.ready) begin
            got.edge_value  = res.edge_value;
            got.out_x       = res.out_x;
            got.out_y       = res.out_y;
            got.last_of_run = res.last_of_run;
            sb.compare_verdict(got);
        end
    end

    task automatic set_idling(int unsigned sender_pct, int unsigned receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    // One pixel transfer, with random gaps ahead of it
    task automatic send_pixel(logic [PIX_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid        <= 1'b1;
        pix.pixel_sample <= value;
        @(negedge i_clk);
        while (!pix.ready) @(negedge i_clk);
        @(posedge i_clk);
        last_pixel = value;
    endtask

    // One register write transfer
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(negedge i_clk);
        while (!cfg.ready) @(negedge i_clk);
        @(posedge i_clk);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering pixels until every owed verdict is out and the pipe is empty
    task automatic drain_results();
        pix.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Pixel content: uniform noise, hard black/white, or smooth ramps with steps
    function automatic logic [PIX_W-1:0] next_pixel(int unsigned style);
        int v;
        case (style)
            0: v = int'($urandom_range(0, 255));
            1: v = $urandom_range(0, 1) ? 255 : 0;
            default: begin
                if ($urandom_range(0, 9) == 0) v = int'($urandom_range(0, 255));
                else v = int'(last_pixel) + int'($urandom_range(0, 40)) - 20;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
        endcase
        return PIX_W'(v);
    endfunction

    // Random frame, usually under fresh settings, sent whole until the item budget runs out
    task automatic random_frame(bit force_config);
        int unsigned r, w, h, thr, brd, n, style;
        logic [CFG_DAT_W-1:0] wdata;
        if (force_config || $urandom_range(0, 3) != 0) begin
            drain_results();
            r = $urandom_range(0, 99);
            if (r < 10)      w = $urandom_range(0, 2);
            else if (r < 80) w = $urandom_range(3, 10);
            else if (r < 95) w = $urandom_range(11, 40);
            else             w = $urandom_range(41, 100);
            r = $urandom_range(0, 99);
            if (r < 10)      h = $urandom_range(0, 2);
            else if (r < 85) h = $urandom_range(3, 7);
            else             h = $urandom_range(8, 14);
            r = $urandom_range(0, 99);
            if (r < 40)      thr = $urandom_range(0, 80);
            else if (r < 70) thr = $urandom_range(81, 200);
            else if (r < 90) thr = $urandom_range(201, 361);
            else             thr = $urandom_range(362, 511);
            r = $urandom_range(0, 9);
            if (r == 0)      brd = 0;
            else if (r == 1) brd = 255;
            else             brd = $urandom_range(0, 255);
            // bits above a register's width are junk the block must drop
            wdata = CFG_DAT_W'(w);
            if ($urandom_range(0, 1))
                wdata = wdata | (CFG_DAT_W'($urandom_range(0, 15)) << CFG_WIDTH_W);
            write_reg(REG_IMAGE_WIDTH, wdata);
            write_reg(REG_IMAGE_HEIGHT, CFG_DAT_W'(h));
            wdata = CFG_DAT_W'(thr);
            if ($urandom_range(0, 1))
                wdata = wdata | (CFG_DAT_W'($urandom_range(0, 127)) << CFG_THR_W);
            write_reg(REG_EDGE_THRESHOLD, wdata);
            wdata = CFG_DAT_W'(brd);
            if ($urandom_range(0, 1))
                wdata = wdata | (CFG_DAT_W'($urandom_range(0, 255)) << CFG_BORDER_W);
            write_reg(REG_BORDER_VALUE, wdata);
        end
        n     = sb.used_width() * sb.used_height();
        style = $urandom_range(0, 2);
        repeat (n) begin
            // the last frame is cut short once the item budget is spent
            if (random_count < RANDOM_ITEMS) begin
                // receiver-heavy idling, then sender-heavy, then none
                if (random_count < RANDOM_ITEMS / 3)          set_idling(26, 57);
                else if (random_count < 2 * RANDOM_ITEMS / 3) set_idling(57, 26);
                else                                          set_idling(0, 0);
                send_pixel(next_pixel(style));
                random_count++;
            end
        end
    endtask

    // Stimulus
    initial begin : stimulus
        int unsigned wait_n;
        bit          first;
        i_rst_n          = 1'b0;
        pix.valid        = 1'b0;
        pix.pixel_sample = '0;
        cfg.valid        = 1'b0;
        cfg.index        = REG_IMAGE_WIDTH;
        cfg.data         = '0;
        hold_request     = 0;
        random_count     = 0;
        last_pixel       = '0;
        set_idling(0, 0);
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Row 0 at reset width, threshold and border; only height is set
        write_reg(REG_IMAGE_HEIGHT, CFG_DAT_W'(3));
        repeat (20) send_pixel(next_pixel(0));
        // widest register value saturates to the line depth, so row 0 runs on
        drain_results();
        write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
        repeat (20) send_pixel(next_pixel(1));
        // shrink width mid-row: column 40 clamps to the new last column, then two rows
        drain_results();
        write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(20));
        repeat (41) send_pixel(next_pixel(2));

        // Directed 3x3 frames: flat gradient at threshold zero, steepest gradient
        drain_results();
        set_idling(26, 57);
        write_reg(REG_EDGE_THRESHOLD, CFG_DAT_W'(0));
        write_reg(REG_BORDER_VALUE, CFG_DAT_W'(255));
        write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(3));
        write_reg(REG_IMAGE_HEIGHT, CFG_DAT_W'(3));
        foreach (CHECKER_FRAME[i]) send_pixel(CHECKER_FRAME[i]);
        drain_results();
        write_reg(REG_EDGE_THRESHOLD, CFG_DAT_W'(359));
        foreach (STEEP_FRAME[i]) send_pixel(STEEP_FRAME[i]);
        // undersized frame used as 3x3; a threshold of 361 never marks an edge
        drain_results();
        write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(0));
        write_reg(REG_IMAGE_HEIGHT, CFG_DAT_W'(2));
        write_reg(REG_EDGE_THRESHOLD, CFG_DAT_W'(361));
        write_reg(REG_BORDER_VALUE, CFG_DAT_W'(0));
        foreach (STEEP_FRAME[i]) send_pixel(STEEP_FRAME[i]);

        // Tallest frame, cut short: row 30 lands past a new height of 4
        drain_results();
        write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(3));
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        write_reg(REG_EDGE_THRESHOLD, CFG_DAT_W'(40));
        write_reg(REG_BORDER_VALUE, CFG_DAT_W'(7));
        repeat (90) send_pixel(next_pixel(2));
        drain_results();
        write_reg(REG_IMAGE_HEIGHT, CFG_DAT_W'(4));
        repeat (3) send_pixel(next_pixel(2));

        // Long sink hold-off while pixels keep coming, so the input backs up
        drain_results();
        write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(16));
        write_reg(REG_IMAGE_HEIGHT, CFG_DAT_W'(5));
        set_idling(0, 0);
        hold_request = HOLD_STRETCH;
        repeat (80) send_pixel(next_pixel(0));

        // Random frames
        first = 1'b1;
        while (random_count < RANDOM_ITEMS) begin
            random_frame(first);
            first = 1'b0;
        end

        // Wind down and report
        pix.valid <= 1'b0;
        for (wait_n = 0; wait_n < FINAL_WAIT && sb.pending() != 0; wait_n++)
            @(posedge i_clk);
        repeat (FINAL_SETTLE) @(posedge i_clk);
        sb.flag_leftovers();
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
src/gedge_pkg.sv
src/gedge_pix_if.sv
src/gedge_res_if.sv
src/gedge_cfg_if.sv
src/gradient_edge_threshold.sv
tb/sv/tb.sv
